// File: sv/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants of the linear contrast stretch block
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int PIX_W       = 8;
  localparam int CFG_INDEX_W = 1;
  localparam logic [PIX_W-1:0] GRAY_MAX = 8'd255;
  localparam logic [PIX_W-1:0] GRAY_MIN = 8'd0;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_LOW  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_HIGH = 1'b1;

  // operation codes
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_STRETCH = 1'b1;

  // quotient bits produced by the divider, one per cycle
  localparam int DIV_STEPS = 9;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } lcs_state_t;

  typedef struct packed {
    logic idle;
    logic mult;
    logic prep;
    logic div_step;
    logic finish;
  } lcs_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_stretch;
    logic in_flat;
    logic out_busy;
  } lcs_status_t;

endpackage

// File: sv/lcs_in_if.sv
// ----------------------------------------------------------------------------
// lcs_in_if
// Pixel request channel: valid, ready and one input pixel
// ----------------------------------------------------------------------------
interface lcs_in_if
  import lcs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [PIX_W-1:0] pixel;
  logic             first_of_frame;
  logic             last_of_frame;

  modport source (output valid, operation, pixel, first_of_frame, last_of_frame,
                  input ready);
  modport sink (input valid, operation, pixel, first_of_frame, last_of_frame,
                output ready);
endinterface

// File: sv/lcs_out_if.sv
// ----------------------------------------------------------------------------
// lcs_out_if
// Result request channel: valid, ready and one stretched pixel
// ----------------------------------------------------------------------------
interface lcs_out_if
  import lcs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] stretched;
  logic             flat_frame;
  logic             last_out;

  modport source (output valid, stretched, flat_frame, last_out, input ready);
  modport sink (input valid, stretched, flat_frame, last_out, output ready);
endinterface

// File: sv/lcs_cfg_if.sv
// ----------------------------------------------------------------------------
// lcs_cfg_if
// Configuration write channel: valid, ready, register index and data
// ----------------------------------------------------------------------------
interface lcs_cfg_if
  import lcs_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [PIX_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/linear_contrast_stretch.sv
// Measure pixels: no result; the next pixel is accepted in the following cycle.
// Stretch pixels: multiply, setup, nine divide steps of the radix-2 divider, then load
// into the output register, which waits while a pending result is not taken; a new pixel
// only after the load. Flat or unmeasured frames skip the divider and go straight to the load.
// Synchronous reset: out_low 0, out_high 255, min 255, max 0, no result pending.
// ----------------------------------------------------------------------------
// linear_contrast_stretch
// Min-max linear gray stretch of one 8-bit channel, two passes per frame
// ----------------------------------------------------------------------------
module linear_contrast_stretch
  import lcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  lcs_in_if.sink    in_ch,
  lcs_out_if.source out_ch,
  lcs_cfg_if.sink   cfg_ch
);

  lcs_cmd_t    cmd;
  lcs_status_t status;

  lcs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  lcs_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .status (status)
  );

  a_stretch_starts_mult: assert property (@(posedge clk) disable iff (rst)
    status.in_fire && status.in_stretch && !status.in_flat |=> cmd.mult)
    else $error("stretch request did not start the multiply");

  a_prep_then_divide: assert property (@(posedge clk) disable iff (rst)
    cmd.prep |=> cmd.div_step)
    else $error("divider setup not followed by a divide step");

  a_finish_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_ch.valid)
    else $error("result load did not raise valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(out_ch.valid && !out_ch.ready))
    else $error("pending result overwritten");

endmodule

// File: sv/lcs_ctrl.sv
// ----------------------------------------------------------------------------
// lcs_ctrl
// Sequencer: multiply, divider setup, nine divide steps, result load; flat frames go straight to the load
// ----------------------------------------------------------------------------
module lcs_ctrl
  import lcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  lcs_status_t status,
  output lcs_cmd_t    cmd
);

  lcs_state_t           state, state_next;
  logic [DIV_CNT_W-1:0] count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.idle = 1'b1;
        if (status.in_fire && status.in_stretch) begin
          state_next = status.in_flat ? ST_DONE : ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        count_next = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        count_next   = count + DIV_CNT_W'(1);
        if (count == DIV_CNT_W'(DIV_STEPS - 1)) begin
          count_next = '0;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/lcs_datapath.sv
// ----------------------------------------------------------------------------
// lcs_datapath
// Min/max tracking, range multiply, radix-2 divider and output register
// ----------------------------------------------------------------------------
module lcs_datapath
  import lcs_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  lcs_in_if.sink         in_ch,
  lcs_out_if.source      out_ch,
  lcs_cfg_if.sink        cfg_ch,
  input  lcs_cmd_t       cmd,
  output lcs_status_t    status
);

  logic [PIX_W-1:0]        frame_min, frame_max;
  logic [PIX_W-1:0]        out_low, out_high;
  logic [PIX_W-1:0]        base_min, base_max;
  logic signed [PIX_W:0]   diff, span;
  logic [PIX_W-1:0]        den;
  logic                    flat, last;
  logic signed [2*PIX_W+1:0] prod;
  logic signed [2*PIX_W+2:0] nsum, nmag;
  logic [2*PIX_W:0]        mag;
  logic [PIX_W:0]          dvs;
  logic                    ovf, ovf_in;
  logic                    neg;
  logic [PIX_W:0]          rem, low, quo;
  logic [PIX_W+1:0]        trial, trial_sub;
  logic                    ge;
  logic [PIX_W+1:0]        qadj;
  logic signed [PIX_W+2:0] qs, vsum;
  logic [PIX_W-1:0]        vsat, result;
  logic                    out_valid;

  // input side
  assign in_ch.ready       = cmd.idle;
  assign cfg_ch.ready      = 1'b1;
  assign status.in_fire    = in_ch.valid & cmd.idle;
  assign status.in_stretch = (in_ch.operation == OP_STRETCH);
  assign status.in_flat    = (frame_max <= frame_min);
  assign status.out_busy   = out_valid & ~out_ch.ready;

  assign base_min = in_ch.first_of_frame ? GRAY_MAX : frame_min;
  assign base_max = in_ch.first_of_frame ? GRAY_MIN : frame_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_min <= GRAY_MAX;
      frame_max <= GRAY_MIN;
      out_low   <= GRAY_MIN;
      out_high  <= GRAY_MAX;
    end else begin
      if (status.in_fire && in_ch.operation == OP_MEASURE) begin
        frame_min <= (in_ch.pixel < base_min) ? in_ch.pixel : base_min;
        frame_max <= (in_ch.pixel > base_max) ? in_ch.pixel : base_max;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_OUT_LOW:  out_low  <= cfg_ch.data;
          REG_OUT_HIGH: out_high <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // divider setup: n = 2*num + den, d = 2*den, floor division on magnitudes
  assign nsum   = $signed({prod, 1'b0}) + $signed({{(PIX_W+3){1'b0}}, den});
  assign neg    = nsum[2*PIX_W+2];
  assign nmag   = neg ? -nsum : nsum;
  assign mag    = nmag[2*PIX_W:0];
  assign dvs    = {den, 1'b0};
  assign ovf_in = {1'b0, mag} >= {dvs, {DIV_STEPS{1'b0}}};

  // one restoring step
  assign trial     = {rem, low[PIX_W]};
  assign trial_sub = trial - {1'b0, dvs};
  assign ge        = trial >= {1'b0, dvs};

  logic neg_r;

  always_ff @(posedge clk) begin
    if (status.in_fire && status.in_stretch) begin
      diff <= $signed({1'b0, in_ch.pixel}) - $signed({1'b0, frame_min});
      span <= $signed({1'b0, out_high}) - $signed({1'b0, out_low});
      den  <= frame_max - frame_min;
      flat <= status.in_flat;
      last <= in_ch.last_of_frame;
    end
    if (cmd.mult) begin
      prod <= $signed({{(PIX_W+1){diff[PIX_W]}}, diff})
            * $signed({{(PIX_W+1){span[PIX_W]}}, span});
    end
    if (cmd.prep) begin
      neg_r <= neg;
      ovf   <= ovf_in;
      rem   <= {1'b0, mag[2*PIX_W:PIX_W+1]};
      low   <= mag[PIX_W:0];
      quo   <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? trial_sub[PIX_W:0] : trial[PIX_W:0];
      low <= {low[PIX_W-1:0], 1'b0};
      quo <= {quo[PIX_W-1:0], ge};
    end
  end

  // signed floor quotient, offset and clamp
  assign qadj = {1'b0, quo} + {{(PIX_W+1){1'b0}}, (rem != '0)};
  assign qs   = neg_r ? -$signed({1'b0, qadj}) : $signed({2'b00, quo});
  assign vsum = $signed({3'b000, out_low}) + qs;

  always_comb begin
    if (vsum[PIX_W+2]) begin
      vsat = GRAY_MIN;
    end else if (vsum[PIX_W+1:PIX_W] != 2'b00) begin
      vsat = GRAY_MAX;
    end else begin
      vsat = vsum[PIX_W-1:0];
    end
    if (flat) begin
      result = out_low;
    end else if (ovf) begin
      result = neg_r ? GRAY_MIN : GRAY_MAX;
    end else begin
      result = vsat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ch.stretched  <= result;
      out_ch.flat_frame <= flat;
      out_ch.last_out   <= last;
    end
  end

  assign out_ch.valid = out_valid;

endmodule
